/* src/rlpe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rlpe_pkg
// shared types, widths and helpers of the recursive length prefix encoder
// ----------------------------------------------------------------------------
package rlpe_pkg;

    localparam int VALUE_W          = 32;
    localparam int COUNT_W          = 6;
    localparam int WORD_W           = 44;
    localparam int LEN_W            = 6;
    localparam int PREFIX_W         = 11;
    localparam int PLEN_W           = 4;
    localparam int MAX_VALUE_BITS_D = 32;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] bit_count;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] code_word;
        logic [LEN_W-1:0]  code_length;
    } t_out_item;

    // stage payload: length prefix plus masked value bits
    typedef struct packed {
        logic                valid;
        logic [PREFIX_W-1:0] prefix;
        logic [PLEN_W-1:0]   prefix_len;
        logic [COUNT_W-1:0]  value_len;
        logic [VALUE_W-1:0]  value_bits;
    } t_pre_stage;

    // saturated input as it leaves the first stage
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_in_stage;

    function automatic logic [2:0] bit_len6(input logic [COUNT_W-1:0] x);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 0; i < COUNT_W; i++) begin
            if (x[i]) begin
                n = 3'(i + 1);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

/* src/rlpe_prefix.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rlpe_prefix
// builds the recursive length prefix and masks the value to its bit count
// ----------------------------------------------------------------------------
module rlpe_prefix import rlpe_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_in_stage  i_stage,
    output t_pre_stage      o_stage
);

    t_pre_stage          r_stage;
    t_pre_stage          n_stage;
    logic [COUNT_W-1:0]  count;
    logic [2:0]          nbits;
    logic [VALUE_W-1:0]  mask;

    always_comb begin
        count = i_stage.item.bit_count;
        nbits = bit_len6(count);
        n_stage.valid      = i_stage.valid;
        n_stage.prefix     = '0;
        n_stage.prefix_len = PLEN_W'(2);
        n_stage.value_len  = '0;
        case (count) inside
            6'd0: begin
                n_stage.prefix = '0;
            end
            6'd1: begin
                n_stage.prefix = PREFIX_W'(1);
            end
            6'd2: begin
                n_stage.prefix = PREFIX_W'(i_stage.item.value[1:0]);
            end
            6'd3: begin
                n_stage.prefix    = PREFIX_W'(3);
                n_stage.value_len = count;
            end
            [6'd4:6'd7]: begin
                n_stage.prefix     = PREFIX_W'({2'b11, count[2:0]});
                n_stage.prefix_len = PLEN_W'(5);
                n_stage.value_len  = count;
            end
            default: begin
                n_stage.prefix     = (PREFIX_W'({2'b11, nbits}) << nbits)
                                     | PREFIX_W'(count);
                n_stage.prefix_len = PLEN_W'(5) + PLEN_W'(nbits);
                n_stage.value_len  = count;
            end
        endcase
        // shift by 32 or more clears, so the mask is then all ones
        mask = ~({VALUE_W{1'b1}} << n_stage.value_len);
        n_stage.value_bits = i_stage.item.value & mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.prefix     <= n_stage.prefix;
        r_stage.prefix_len <= n_stage.prefix_len;
        r_stage.value_len  <= n_stage.value_len;
        r_stage.value_bits <= n_stage.value_bits;
    end

    assign o_stage = r_stage;

endmodule
`default_nettype wire

/* src/rlpe_pack.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rlpe_pack
// joins prefix, value bits and terminating zero into the output code word
// ----------------------------------------------------------------------------
module rlpe_pack import rlpe_pkg::*; #(
    parameter int MAX_VALUE_BITS = MAX_VALUE_BITS_D
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_pre_stage i_stage,
    output logic            o_valid,
    output t_out_item       o_result
);

    localparam int CODE_W = MAX_VALUE_BITS + PREFIX_W + 1;

    logic              r_valid;
    t_out_item         r_result;
    t_out_item         n_result;
    logic [6:0]        shamt;
    logic [CODE_W-1:0] code;
    logic [6:0]        len;

    always_comb begin
        shamt = 7'(i_stage.value_len) + 7'd1;
        code  = (CODE_W'(i_stage.prefix) << shamt)
                | (CODE_W'(i_stage.value_bits) << 1);
        len   = 7'(i_stage.prefix_len) + shamt;
        n_result.code_word   = WORD_W'(code);
        n_result.code_length = LEN_W'(len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

/* src/recursive_length_prefix_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// recursive_length_prefix_encoder
// elias omega style universal code of a value and its bit count
// ----------------------------------------------------------------------------
// A transfer is taken on every clock edge with start high; busy stays low, so
// one item enters per cycle. Each result appears on o_result for one cycle
// with o_valid high, once its transfer has passed the three register stages
// (count saturation, prefix build, code assembly). The receiver cannot stall
// the block and must take each result when o_valid is high. Counts above
// MAX_VALUE_BITS are saturated to it.
// ----------------------------------------------------------------------------
module recursive_length_prefix_encoder import rlpe_pkg::*; #(
    parameter int MAX_VALUE_BITS = MAX_VALUE_BITS_D
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    output t_out_item      o_result
);

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_VALUE_BITS);

    t_in_stage  r_s1;
    t_in_stage  n_s1;
    t_pre_stage s2;

    always_comb begin
        n_s1.valid      = start;
        n_s1.item.value = i_item.value;
        if (i_item.bit_count > MAX_CNT) begin
            n_s1.item.bit_count = MAX_CNT;
        end else begin
            n_s1.item.bit_count = i_item.bit_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
        end
        r_s1.item <= n_s1.item;
    end

    rlpe_prefix u_prefix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (r_s1),
        .o_stage (s2)
    );

    rlpe_pack #(
        .MAX_VALUE_BITS (MAX_VALUE_BITS)
    ) u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (s2),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    assign busy = 1'b0;

endmodule
`default_nettype wire

/* tb/sv/tb_recursive_length_prefix_encoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_recursive_length_prefix_encoder
// self-checking bench of the recursive length prefix encoder
// ----------------------------------------------------------------------------
// Every item taken by the encoder is coded again by a predictor in the
// scoreboard, and each strobed result is compared in order against it. A
// directed set of counts and values runs first, then about two thousand
// random items with random gaps between transfers and stretches with none.
// ----------------------------------------------------------------------------
import rlpe_pkg::*;

class code_scoreboard;

    localparam int SAT_COUNT = MAX_VALUE_BITS_D;

    t_out_item   pending_codes[$];
    int unsigned mismatches;
    int unsigned items_taken;
    int unsigned codes_checked;
    bit          count_seen[64];

    // number of significant bits of a small count
    function automatic int unsigned width_of(int unsigned x);
        int unsigned n;
        n = 0;
        while (x != 0 && n < 8) begin
            x = x >> 1;
            n++;
        end
        return n;
    endfunction

    // code of one item: chain of counts down to a base group of two bits,
    // then each level's bits from the innermost outward, then a zero
    function automatic t_out_item omega_code(t_in_item it);
        logic [63:0] acc;
        logic [63:0] lvl_val[8];
        int unsigned lvl_cnt[8];
        int unsigned len;
        int          depth;
        t_out_item   res;
        lvl_cnt[0] = it.bit_count;
        if (lvl_cnt[0] > SAT_COUNT) begin
            lvl_cnt[0] = SAT_COUNT;
        end
        lvl_val[0] = 64'(it.value);
        depth = 0;
        while (lvl_cnt[depth] >= 3) begin
            lvl_val[depth+1] = 64'(lvl_cnt[depth]);
            lvl_cnt[depth+1] = width_of(lvl_cnt[depth]);
            depth++;
        end
        case (lvl_cnt[depth])
            0: begin
                acc = 64'd0;
            end
            1: begin
                acc = 64'd1;
            end
            default: begin
                acc = lvl_val[depth] & 64'd3;
            end
        endcase
        len = 2;
        for (int k = depth - 1; k >= 0; k--) begin
            acc = (acc << lvl_cnt[k]) | (lvl_val[k] & ((64'd1 << lvl_cnt[k]) - 64'd1));
            len += lvl_cnt[k];
        end
        acc = acc << 1;
        len += 1;
        res.code_word   = acc[WORD_W-1:0];
        res.code_length = len[LEN_W-1:0];
        return res;
    endfunction

    function void note_input(t_in_item it);
        pending_codes.push_back(omega_code(it));
        count_seen[it.bit_count] = 1'b1;
        items_taken++;
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        codes_checked++;
        if (pending_codes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected code word %h length %0d", got.code_word,
                         got.code_length);
            end
            return;
        end
        want = pending_codes.pop_front();
        if (got.code_word !== want.code_word || got.code_length !== want.code_length) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("code mismatch: expected word %h length %0d, got word %h length %0d",
                         want.code_word, want.code_length, got.code_word, got.code_length);
            end
        end
    endfunction

    function int unsigned counts_covered();
        int unsigned n;
        n = 0;
        foreach (count_seen[i]) begin
            n += count_seen[i];
        end
        return n;
    endfunction

endclass

module tb_recursive_length_prefix_encoder;

    localparam int RANDOM_ITEMS = 2000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_valid;
    t_out_item o_result;

    code_scoreboard sb = new;

    recursive_length_prefix_encoder DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result(o_result);
        end
    end

    // drop start for the gap, then hold the item until a transfer
    task automatic send_item(input t_in_item it, input int unsigned gap);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_input(it);
    endtask

    task automatic send_pair(input logic [31:0] v, input logic [5:0] c,
                             input int unsigned gap);
        t_in_item it;
        it.value     = v;
        it.bit_count = c;
        send_item(it, gap);
    endtask

    function automatic logic [31:0] draw_value();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned gap;
        bit          no_gaps;
        logic [5:0]  cnt;
        start   <= 1'b0;
        i_item  <= '0;
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: base groups, count boundaries, saturation
        send_pair(32'd0,          6'd0,  0);
        send_pair(32'hFFFF_FFFF,  6'd0,  0);
        send_pair(32'd0,          6'd1,  1);
        send_pair(32'd1,          6'd1,  0);
        send_pair(32'hFFFF_FFFE,  6'd1,  2);
        send_pair(32'd2,          6'd2,  0);
        send_pair(32'hFFFF_FFFD,  6'd2,  0);
        send_pair(32'd5,          6'd3,  3);
        send_pair(32'hFFFF_FFFF,  6'd3,  0);
        send_pair(32'hA,          6'd4,  0);
        send_pair(32'h7F,         6'd7,  13);
        send_pair(32'h80,         6'd8,  0);
        send_pair(32'h5555_5555,  6'd15, 0);
        send_pair(32'hFFFF_0000,  6'd16, 1);
        send_pair(32'hFFFF_FFFF,  6'd31, 0);
        send_pair(32'hFFFF_FFFF,  6'd32, 0);
        send_pair(32'd0,          6'd32, 0);
        send_pair(32'h8000_0001,  6'd32, 4);
        send_pair(32'hDEAD_BEEF,  6'd33, 0);
        send_pair(32'hFFFF_FFFF,  6'd40, 0);
        send_pair(32'hFFFF_FFFF,  6'd63, 7);
        send_pair(32'd0,          6'd63, 0);
        send_pair(32'hFFFF_FFF0,  6'd4,  0);

        no_gaps = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            gap = no_gaps ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 9) == 0) begin
                cnt = 6'($urandom_range(33, 63));
            end else begin
                cnt = 6'($urandom_range(0, 32));
            end
            send_pair(draw_value(), cnt, gap);
        end
        start <= 1'b0;

        while (sb.pending_codes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("encoded %0d items, checked %0d code words, %0d of 64 counts exercised",
                 sb.items_taken, sb.codes_checked, sb.counts_covered());
        $display("mismatches %0d, codes still owed %0d", sb.mismatches,
                 sb.pending_codes.size());
        if (sb.mismatches == 0 && sb.pending_codes.size() == 0) begin
            $display("tb_recursive_length_prefix_encoder: clean");
        end else begin
            $display("tb_recursive_length_prefix_encoder: errors");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout waiting for encoder");
        $display("tb_recursive_length_prefix_encoder: errors");
        $finish;
    end

endmodule
